>>> rtl/wto_pkg.sv
package wto_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 16;

  localparam int ADDR_W  = 12;
  localparam int VALUE_W = 16;
  localparam int GAIN_W  = 17;
  localparam int INC_W   = 28;
  localparam int LEN_W   = 13;

  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  localparam int MIN_LEN = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [GAIN_W-1:0]    GAIN_ONE  = 17'h10000;
  localparam logic [LEN_W-1:0]     LEN_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_WRITE       = 2'd1,
    CMD_RESET_PHASE = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                op;
    logic [ADDR_W-1:0]   addr;
    logic [VALUE_W-1:0]  value;
    logic [GAIN_W-1:0]   gain;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_READ_B
  } seq_state_t;

endpackage

>>> rtl/wto_front.sv
module wto_front #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wto_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [wto_pkg::CMD_W-1:0]        in_tuser,
  input  wto_pkg::q_status_t               q_stat,
  output logic                             push,
  output wto_pkg::entry_t                  push_entry
);

  localparam int AW_IN = wto_pkg::ADDR_W;
  localparam int VW    = wto_pkg::VALUE_W;
  localparam int GW    = wto_pkg::GAIN_W;

  logic                 hold_v_r, hold_v_nxt;
  wto_pkg::entry_t      hold_r, hold_nxt;
  logic                 keep_c;
  logic [AW_IN-1:0]     addr_c;
  logic [VW-1:0]        value_c;
  logic [GW-1:0]        gain_c;
  wto_pkg::cmd_t        cmd_c;

  assign addr_c  = in_tdata[AW_IN-1:0];
  assign value_c = in_tdata[AW_IN +: VW];
  assign gain_c  = in_tdata[AW_IN+VW +: GW];
  assign cmd_c   = wto_pkg::cmd_t'(in_tuser);

  assign in_tready  = !hold_v_r || !q_stat.full;
  assign push       = hold_v_r && !q_stat.full;
  assign push_entry = hold_r;

  // unused codes and writes past the table are dropped here
  always_comb begin
    keep_c = 1'b0;
    case (cmd_c)
      wto_pkg::CMD_TICK:        keep_c = 1'b1;
      wto_pkg::CMD_WRITE:       keep_c = (32'(addr_c) < 32'(TABLE_DEPTH));
      wto_pkg::CMD_RESET_PHASE: keep_c = 1'b1;
      default:                  keep_c = 1'b0;
    endcase

    hold_nxt       = hold_r;
    hold_nxt.op    = cmd_c;
    hold_nxt.addr  = addr_c;
    hold_nxt.value = value_c;
    hold_nxt.gain  = (gain_c > wto_pkg::GAIN_ONE) ? wto_pkg::GAIN_ONE : gain_c;

    hold_v_nxt = hold_v_r;
    if (in_tready) begin
      hold_v_nxt = in_tvalid && keep_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

>>> rtl/wto_queue.sv
module wto_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wto_pkg::entry_t    push_entry,
  input  logic               pop,
  output wto_pkg::q_status_t q_stat,
  output wto_pkg::entry_t    head
);

  localparam int DEPTH = wto_pkg::QUEUE_DEPTH;
  localparam int PW    = wto_pkg::Q_PTR_W;
  localparam int CW    = wto_pkg::Q_CNT_W;

  wto_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign q_stat.not_empty = (count_r != '0);
  assign q_stat.full      = (count_r == CW'(DEPTH));
  assign head             = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/wto_back.sv
module wto_back #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [wto_pkg::INC_W-1:0]        phase_increment,
  input  logic [wto_pkg::LEN_W-1:0]        table_length,
  input  wto_pkg::q_status_t               q_stat,
  input  wto_pkg::entry_t                  head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wto_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int FB    = wto_pkg::FRAC_BITS;
  localparam int SB    = wto_pkg::SAMPLE_BITS;
  localparam int GB    = wto_pkg::GAIN_BITS;
  localparam int GW    = wto_pkg::GAIN_W;
  localparam int INCW  = wto_pkg::INC_W;
  localparam int LENW  = wto_pkg::LEN_W;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW    = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = LW + FB;
  localparam int CMP_W = (INCW > LIM_W) ? INCW : LIM_W;
  localparam int LEN_CAP = (1 << LENW) - 1;
  localparam int MAX_LEN = (TABLE_DEPTH < LEN_CAP) ? TABLE_DEPTH : LEN_CAP;
  localparam int P1_W  = FB + SB + 2;
  localparam int P2_W  = SB + GW + 2;
  localparam int ODEPTH = wto_pkg::OUT_DEPTH;
  localparam int OPW   = wto_pkg::OUT_PTR_W;
  localparam int OCW   = wto_pkg::OUT_CNT_W;
  localparam int ODW   = wto_pkg::OUT_DATA_W;

  localparam logic signed [P2_W-1:0] ROUND_HALF = P2_W'(1) << (GB - 1);
  localparam logic signed [P2_W-1:0] Y_HI = (P2_W'(1) << (SB - 1)) - P2_W'(1);
  localparam logic signed [P2_W-1:0] Y_LO = ~Y_HI;

  // derived settings, refreshed every cycle
  logic [LW-1:0]    len_c, len_r;
  logic [LIM_W-1:0] lim_c, lim_r;
  logic [LIM_W-1:0] inc_c, inc_r;

  wto_pkg::seq_state_t state_r, state_nxt;
  logic [LIM_W-1:0] phase_r, phase_nxt;
  logic [LIM_W-1:0] phase_norm_c;
  logic [LIM_W:0]   sum_c, wrap_c;
  logic [LW-1:0]    left_c, left_inc_c, right_c;
  logic [AW-1:0]    right_r;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  logic [SB-1:0]    wave_mem [TABLE_DEPTH];
  logic [SB-1:0]    rdata_r;

  logic             tick_start, phase_clear, phase_step, can_start;

  logic             v0_r, v1_r, v2_r, v3_r;
  logic [FB-1:0]    frac0_r, frac1_r;
  logic [GW-1:0]    gain0_r, gain1_r, gain2_r;
  logic [SB-1:0]    a1_r, a2_r;
  logic signed [SB:0]      diff_c;
  logic signed [P1_W-1:0]  prod1_c, prod1_r, shift_c;
  logic signed [SB:0]      interp_c;
  logic signed [P2_W-1:0]  prod2_c, prod2_r, rnd_c, y_c;
  logic [SB-1:0]    sample_c;

  logic [ODW-1:0]   ofifo_r [ODEPTH];
  logic [OPW-1:0]   owptr_r, orptr_r;
  logic [OCW-1:0]   ocount_r, credit_r;
  logic             out_take;

  // settings clamp
  always_comb begin
    if (table_length < LENW'(wto_pkg::MIN_LEN)) begin
      len_c = LW'(wto_pkg::MIN_LEN);
    end else if (32'(table_length) > 32'(MAX_LEN)) begin
      len_c = LW'(MAX_LEN);
    end else begin
      len_c = LW'(table_length);
    end
    lim_c = {len_c, {FB{1'b0}}};
    if (CMP_W'(phase_increment) > CMP_W'(lim_c)) begin
      inc_c = lim_c;
    end else begin
      inc_c = LIM_W'(phase_increment);
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_c;
    lim_r <= lim_c;
    inc_r <= inc_c;
  end

  // phase and neighbor addresses
  assign phase_norm_c = (phase_r >= lim_r) ? '0 : phase_r;
  assign left_c       = phase_norm_c[LIM_W-1:FB];
  assign left_inc_c   = left_c + LW'(1);
  assign right_c      = (left_inc_c >= len_r) ? '0 : left_inc_c;
  assign sum_c        = {1'b0, phase_r} + {1'b0, inc_r};
  assign wrap_c       = sum_c - {1'b0, lim_r};
  assign can_start    = (credit_r < OCW'(ODEPTH));

  always_comb begin
    state_nxt   = state_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = AW'(left_c);
    tick_start  = 1'b0;
    phase_clear = 1'b0;
    phase_step  = 1'b0;
    case (state_r)
      wto_pkg::SEQ_IDLE: begin
        if (q_stat.not_empty) begin
          case (head.op)
            wto_pkg::CMD_WRITE: begin
              pop      = 1'b1;
              mem_we   = 1'b1;
              mem_addr = AW'(head.addr);
            end
            wto_pkg::CMD_RESET_PHASE: begin
              pop         = 1'b1;
              phase_clear = 1'b1;
            end
            wto_pkg::CMD_TICK: begin
              if (can_start) begin
                pop        = 1'b1;
                mem_re     = 1'b1;
                tick_start = 1'b1;
                state_nxt  = wto_pkg::SEQ_READ_B;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      wto_pkg::SEQ_READ_B: begin
        mem_re     = 1'b1;
        mem_addr   = right_r;
        phase_step = 1'b1;
        state_nxt  = wto_pkg::SEQ_IDLE;
      end
      default: begin
        state_nxt = wto_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (phase_clear) begin
      phase_nxt = '0;
    end else if (tick_start) begin
      phase_nxt = phase_norm_c;
    end else if (phase_step) begin
      phase_nxt = (sum_c >= {1'b0, lim_r}) ? wrap_c[LIM_W-1:0] : sum_c[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wto_pkg::SEQ_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // single-port sample table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wave_mem[mem_addr] <= head.value[SB-1:0];
    end
    if (mem_re) begin
      rdata_r <= wave_mem[mem_addr];
    end
  end

  // arithmetic pipeline, fixed latency, never stalls
  assign diff_c   = $signed({rdata_r[SB-1], rdata_r}) - $signed({a1_r[SB-1], a1_r});
  assign prod1_c  = $signed({1'b0, frac1_r}) * diff_c;
  assign shift_c  = prod1_r >>> FB;
  assign interp_c = $signed({a2_r[SB-1], a2_r}) + $signed(shift_c[SB:0]);
  assign prod2_c  = interp_c * $signed({1'b0, gain2_r});
  assign rnd_c    = prod2_r + ROUND_HALF;
  assign y_c      = rnd_c >>> GB;

  always_comb begin
    if (y_c > Y_HI) begin
      sample_c = Y_HI[SB-1:0];
    end else if (y_c < Y_LO) begin
      sample_c = Y_LO[SB-1:0];
    end else begin
      sample_c = y_c[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= tick_start;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_start) begin
      right_r <= AW'(right_c);
      frac0_r <= phase_norm_c[FB-1:0];
      gain0_r <= head.gain;
    end
    // rdata_r holds the left entry while v0_r is high
    a1_r    <= rdata_r;
    frac1_r <= frac0_r;
    gain1_r <= gain0_r;
    prod1_r <= prod1_c;
    a2_r    <= a1_r;
    gain2_r <= gain1_r;
    prod2_r <= prod2_c;
  end

  // result queue; ticks start only while a slot is free for them
  assign out_tvalid = (ocount_r != '0);
  assign out_tdata  = ofifo_r[orptr_r];
  assign out_take   = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r  <= '0;
      orptr_r  <= '0;
      ocount_r <= '0;
      credit_r <= '0;
    end else begin
      if (v3_r) begin
        owptr_r <= (owptr_r == OPW'(ODEPTH - 1)) ? '0 : owptr_r + OPW'(1);
      end
      if (out_take) begin
        orptr_r <= (orptr_r == OPW'(ODEPTH - 1)) ? '0 : orptr_r + OPW'(1);
      end
      ocount_r <= ocount_r + OCW'(v3_r) - OCW'(out_take);
      credit_r <= credit_r + OCW'(tick_start) - OCW'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      ofifo_r[owptr_r] <= ODW'(sample_c);
    end
  end

endmodule

>>> rtl/wavetable_oscillator_lerp_core.sv
// channel | dir | payload (lowest bit first)                          | accept
// in_     | in  | tdata: table_addr 12, table_value 16, envelope_gain 17; | tvalid & tready
//         |     | tuser: cmd 2                                          |
// out_    | out | tdata: sample_out 16                                  | tvalid & tready
// cfg_    | in  | index 2, data 28 (0 phase_increment, 1 table_length)  | valid & ready
//
// A tick uses the sequencer's IDLE and READ_B states: the left and right
// samples are read in turn from the single-port table. Writes and phase
// resets are handled in IDLE. A tick's result goes through the v0-v3 stages.
// Reset is synchronous; the table is not cleared and must be written first.
// A 2-entry queue sits between intake and sequencer; a 4-entry result queue
// lets ticks run ahead of a stalled output.
module wavetable_oscillator_lerp_core #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // table_addr [11:0], table_value [27:12], envelope_gain [44:28]
  input  logic [wto_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd [1:0]
  input  logic [wto_pkg::CMD_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sample_out [15:0]
  output logic [wto_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wto_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int INCW = wto_pkg::INC_W;
  localparam int LENW = wto_pkg::LEN_W;

  logic [INCW-1:0]    phase_inc_r, phase_inc_nxt;
  logic [LENW-1:0]    table_len_r, table_len_nxt;

  logic               q_push;
  logic               q_pop;
  wto_pkg::entry_t    q_entry;
  wto_pkg::entry_t    q_head;
  wto_pkg::q_status_t q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    phase_inc_nxt = phase_inc_r;
    table_len_nxt = table_len_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wto_pkg::REG_PHASE_INC: phase_inc_nxt = cfg_data[INCW-1:0];
        wto_pkg::REG_TABLE_LEN: table_len_nxt = cfg_data[LENW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      table_len_r <= wto_pkg::LEN_RESET;
    end else begin
      phase_inc_r <= phase_inc_nxt;
      table_len_r <= table_len_nxt;
    end
  end

  wto_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (q_entry)
  );

  wto_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .q_stat     (q_stat),
    .head       (q_head)
  );

  wto_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .phase_increment (phase_inc_r),
    .table_length    (table_len_r),
    .q_stat          (q_stat),
    .head            (q_head),
    .pop             (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.not_empty)
    else $error("queue pop while empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !q_stat.not_empty)
    else $error("queues not empty after reset");
`endif

endmodule
